/* sv/ldbc_pkg.sv */
// Shared types, constants and the log2 fraction table for the brightness curve.
`default_nettype none
package ldbc_pkg;

  localparam int DefMaxPoints = 7;
  localparam int DefLuxBits   = 17;

  localparam int RegW     = 33;
  localparam int BrightW  = 16;
  localparam int PtLuxW   = 17;
  localparam int CfgIdxW  = 3;
  localparam int CountW   = 3;
  localparam int FracW    = 16;
  localparam int RatioW   = 17;
  localparam int QuotW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [RatioW-1:0]  RATIO_ONE       = 17'h10000;

  typedef struct packed {
    logic vld;
    logic ok;
  } ctl_t;

  // round(65536*log2(1+k/16)) for k = 0..16
  function automatic logic [16:0] log_frac(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/ldbc_log2.sv */
// Registered log2(1+x) in Q(e).16: leading-one position plus interpolated fraction table.
`default_nettype none
module ldbc_log2 #(
  parameter int LUX_BITS = ldbc_pkg::DefLuxBits
) (
  input  wire logic                                 clk_i,
  input  wire logic [LUX_BITS-1:0]                  x_i,
  output logic [$clog2(LUX_BITS+1)+ldbc_pkg::FracW-1:0] log_o
);
  import ldbc_pkg::*;

  localparam int VB = LUX_BITS + 1;
  localparam int EW = $clog2(VB);
  localparam int LW = EW + FracW;

  logic [VB-1:0]       v;
  logic [EW-1:0]       e;
  logic [EW-1:0]       sh;
  logic [VB+FracW-1:0] ext;
  logic [FracW-1:0]    f;
  logic [16:0]         t_lo;
  logic [16:0]         t_hi;
  logic [16:0]         t_d;
  logic [28:0]         prod;
  logic [LW-1:0]       log_d;
  logic [LW-1:0]       log_q;

  always_comb begin
    v = {1'b0, x_i} + VB'(1);
    e = '0;
    for (int i = 0; i < VB; i++) begin
      if (v[i]) e = EW'(i);
    end
    // normalize so the leading one sits at the top, fraction right below
    sh    = EW'(VB - 1) - e;
    ext   = {v, {FracW{1'b0}}} << sh;
    f     = ext[VB+FracW-2 -: FracW];
    t_lo  = log_frac({1'b0, f[15:12]});
    t_hi  = log_frac({1'b0, f[15:12]} + 5'd1);
    t_d   = t_hi - t_lo;
    prod  = 29'(t_d) * 29'(f[11:0]);
    log_d = {e, {FracW{1'b0}}} + LW'(t_lo) + LW'(prod[28:12]);
  end

  always_ff @(posedge clk_i) begin
    log_q <= log_d;
  end

  assign log_o = log_q;

endmodule
`default_nettype wire

/* sv/ldbc_seg.sv */
// Curve check and segment search: picks the bracketing points or the clamp brightness.
`default_nettype none
module ldbc_seg #(
  parameter int MAX_POINTS = ldbc_pkg::DefMaxPoints,
  parameter int LUX_BITS   = ldbc_pkg::DefLuxBits
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            vld_i,
  input  wire logic [LUX_BITS-1:0]             lux_i,
  input  wire logic [ldbc_pkg::CountW-1:0]     point_count_i,
  input  wire logic [ldbc_pkg::RegW-1:0]       points_i [MAX_POINTS],
  output ldbc_pkg::ctl_t                       ctl_o,
  output logic [LUX_BITS-1:0]                  lux_o,
  output logic [LUX_BITS-1:0]                  lux_lo_o,
  output logic [LUX_BITS-1:0]                  lux_hi_o,
  output logic [ldbc_pkg::BrightW-1:0]         b_lo_o,
  output logic [ldbc_pkg::BrightW-1:0]         b_hi_o
);
  import ldbc_pkg::*;

  localparam int PLW = (LUX_BITS < PtLuxW) ? LUX_BITS : PtLuxW;

  logic [LUX_BITS-1:0] plux [MAX_POINTS];
  logic [BrightW-1:0]  pb   [MAX_POINTS];
  logic                ok;
  logic [CountW-1:0]   last;
  logic [CountW-1:0]   hi;
  logic [LUX_BITS-1:0] lux_last;
  logic [BrightW-1:0]  b_last;
  logic [LUX_BITS-1:0] sel_lux_lo;
  logic [LUX_BITS-1:0] sel_lux_hi;
  logic [BrightW-1:0]  sel_b_lo;
  logic [BrightW-1:0]  sel_b_hi;
  logic [BrightW-1:0]  b_lo_d;
  logic [BrightW-1:0]  b_hi_d;

  ctl_t                ctl_q;
  logic [LUX_BITS-1:0] lux_q;
  logic [LUX_BITS-1:0] lux_lo_q;
  logic [LUX_BITS-1:0] lux_hi_q;
  logic [BrightW-1:0]  b_lo_q;
  logic [BrightW-1:0]  b_hi_q;

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      plux[i] = LUX_BITS'(points_i[i][BrightW +: PLW]);
      pb[i]   = points_i[i][BrightW-1:0];
    end
    ok = (point_count_i >= CountW'(2)) && (point_count_i <= CountW'(MAX_POINTS));
    for (int i = 1; i < MAX_POINTS; i++) begin
      if (CountW'(i) < point_count_i) begin
        if (plux[i] <= plux[i-1]) ok = 1'b0;
        if (pb[i] < pb[i-1])      ok = 1'b0;
      end
    end
    last = point_count_i - CountW'(1);
    // first point above the reading, lowest index wins
    hi = CountW'(1);
    for (int i = MAX_POINTS - 1; i >= 1; i--) begin
      if (CountW'(i) <= last && lux_i < plux[i]) hi = CountW'(i);
    end
    lux_last   = '0;
    b_last     = '0;
    sel_lux_lo = '0;
    sel_lux_hi = '0;
    sel_b_lo   = '0;
    sel_b_hi   = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (CountW'(i) == last) begin
        lux_last = plux[i];
        b_last   = pb[i];
      end
      if (CountW'(i) == hi) begin
        sel_lux_hi = plux[i];
        sel_b_hi   = pb[i];
      end
      if (CountW'(i + 1) == hi) begin
        sel_lux_lo = plux[i];
        sel_b_lo   = pb[i];
      end
    end
    // clamped and invalid items carry equal ends, so the blend adds nothing
    if (!ok) begin
      b_lo_d = '0;
      b_hi_d = '0;
    end else if (lux_i <= plux[0]) begin
      b_lo_d = pb[0];
      b_hi_d = pb[0];
    end else if (lux_i >= lux_last) begin
      b_lo_d = b_last;
      b_hi_d = b_last;
    end else begin
      b_lo_d = sel_b_lo;
      b_hi_d = sel_b_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.vld <= vld_i;
      ctl_q.ok  <= ok;
    end
  end

  always_ff @(posedge clk_i) begin
    lux_q    <= lux_i;
    lux_lo_q <= sel_lux_lo;
    lux_hi_q <= sel_lux_hi;
    b_lo_q   <= b_lo_d;
    b_hi_q   <= b_hi_d;
  end

  assign ctl_o    = ctl_q;
  assign lux_o    = lux_q;
  assign lux_lo_o = lux_lo_q;
  assign lux_hi_o = lux_hi_q;
  assign b_lo_o   = b_lo_q;
  assign b_hi_o   = b_hi_q;

endmodule
`default_nettype wire

/* sv/ldbc_div.sv */
// Pipelined restoring divider for the Q1.16 ratio, four quotient bits per stage.
`default_nettype none
module ldbc_div #(
  parameter int LW   = 21,
  parameter int SB_W = 33
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        vld_i,
  input  wire logic [LW-1:0]               num_i,
  input  wire logic [LW-1:0]               den_i,
  input  wire logic [SB_W-1:0]             side_i,
  output logic                             vld_o,
  output logic [ldbc_pkg::RatioW-1:0]      ratio_o,
  output logic [SB_W-1:0]                  side_o
);
  import ldbc_pkg::*;

  localparam int BitsPerStage = 4;
  localparam int NST          = QuotW / BitsPerStage;

  logic            vld_q  [NST+1];
  logic [LW-1:0]   rem_q  [NST+1];
  logic [LW-1:0]   den_q  [NST+1];
  logic [QuotW-1:0] quo_q [NST+1];
  logic            zero_q [NST+1];
  logic            full_q [NST+1];
  logic [SB_W-1:0] side_q [NST+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i;
    den_q[0]  <= den_i;
    quo_q[0]  <= '0;
    zero_q[0] <= (den_i == '0);
    // quotient reaches one or more: saturate
    full_q[0] <= (num_i >= den_i);
    side_q[0] <= side_i;
  end

  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic [LW:0]      t;
    logic [LW-1:0]    rem_n;
    logic [QuotW-1:0] quo_n;

    always_comb begin
      rem_n = rem_q[j];
      quo_n = quo_q[j];
      t     = '0;
      for (int s = 0; s < BitsPerStage; s++) begin
        t = {rem_n, 1'b0};
        if (t >= {1'b0, den_q[j]}) begin
          t     = t - {1'b0, den_q[j]};
          quo_n = {quo_n[QuotW-2:0], 1'b1};
        end else begin
          quo_n = {quo_n[QuotW-2:0], 1'b0};
        end
        rem_n = t[LW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= rem_n;
      den_q[j+1]  <= den_q[j];
      quo_q[j+1]  <= quo_n;
      zero_q[j+1] <= zero_q[j];
      full_q[j+1] <= full_q[j];
      side_q[j+1] <= side_q[j];
    end
  end

  assign vld_o   = vld_q[NST];
  assign side_o  = side_q[NST];
  assign ratio_o = zero_q[NST] ? '0 :
                   full_q[NST] ? RATIO_ONE : {1'b0, quo_q[NST]};

endmodule
`default_nettype wire

/* sv/log_domain_brightness_curve_top.sv */
// Ambient light to brightness through a log-domain piecewise-linear curve.
//
// One lux reading is taken per cycle (busy_o stays low) and its brightness
// appears on result_valid_o for one cycle; the receiver cannot hold results
// off. Each reading passes in order through the stage chain:
// segment search, three log2 units, a 5-stage divider (setup plus four
// stages of four quotient bits), the slope multiply and the final add.
// Curve registers are taken through the cfg channel, which is always ready.
`default_nettype none
module log_domain_brightness_curve_top #(
  parameter int MAX_POINTS = ldbc_pkg::DefMaxPoints,
  parameter int LUX_BITS   = ldbc_pkg::DefLuxBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [LUX_BITS-1:0]           lux_reading_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ldbc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ldbc_pkg::RegW-1:0]     cfg_data_i,
  output logic                               result_valid_o,
  output logic [ldbc_pkg::BrightW-1:0]       brightness_level_o,
  output logic                               curve_ok_o
);
  import ldbc_pkg::*;

  localparam int LW   = $clog2(LUX_BITS + 1) + FracW;
  localparam int SB_W = 1 + 2 * BrightW;

  logic [CountW-1:0] point_count_q;
  logic [RegW-1:0]   points_q [MAX_POINTS];

  ctl_t                seg_ctl;
  logic [LUX_BITS-1:0] seg_lux;
  logic [LUX_BITS-1:0] seg_lux_lo;
  logic [LUX_BITS-1:0] seg_lux_hi;
  logic [BrightW-1:0]  seg_b_lo;
  logic [BrightW-1:0]  seg_b_hi;

  logic [LW-1:0]       log_x;
  logic [LW-1:0]       log_lo;
  logic [LW-1:0]       log_hi;
  ctl_t                lg_ctl_q;
  logic [BrightW-1:0]  lg_b_lo_q;
  logic [BrightW-1:0]  lg_b_hi_q;

  logic [LW-1:0]       num;
  logic [LW-1:0]       den;

  logic                dv_vld;
  logic [RatioW-1:0]   dv_ratio;
  logic [SB_W-1:0]     dv_side;
  logic [BrightW-1:0]  dv_b_lo;
  logic [BrightW-1:0]  dv_b_hi;

  ctl_t                ml_ctl_q;
  logic [BrightW-1:0]  ml_b_lo_q;
  logic [RatioW+BrightW-1:0] ml_prod_q;

  logic                out_vld_q;
  logic [BrightW-1:0]  out_b_q;
  logic                out_ok_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // register writes, indexes past the last stored point drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      for (int i = 0; i < MAX_POINTS; i++) points_q[i] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_POINT_COUNT) point_count_q <= cfg_data_i[CountW-1:0];
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_index_i == CfgIdxW'(i + 1)) points_q[i] <= cfg_data_i;
      end
    end
  end

  ldbc_seg #(
    .MAX_POINTS (MAX_POINTS),
    .LUX_BITS   (LUX_BITS)
  ) u_seg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (start_i && !busy_o),
    .lux_i         (lux_reading_i),
    .point_count_i (point_count_q),
    .points_i      (points_q),
    .ctl_o         (seg_ctl),
    .lux_o         (seg_lux),
    .lux_lo_o      (seg_lux_lo),
    .lux_hi_o      (seg_lux_hi),
    .b_lo_o        (seg_b_lo),
    .b_hi_o        (seg_b_hi)
  );

  ldbc_log2 #(.LUX_BITS(LUX_BITS)) u_log_x  (.clk_i(clk_i), .x_i(seg_lux),    .log_o(log_x));
  ldbc_log2 #(.LUX_BITS(LUX_BITS)) u_log_lo (.clk_i(clk_i), .x_i(seg_lux_lo), .log_o(log_lo));
  ldbc_log2 #(.LUX_BITS(LUX_BITS)) u_log_hi (.clk_i(clk_i), .x_i(seg_lux_hi), .log_o(log_hi));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_ctl_q <= '0;
    end else begin
      lg_ctl_q <= seg_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    lg_b_lo_q <= seg_b_lo;
    lg_b_hi_q <= seg_b_hi;
  end

  assign den = (log_hi > log_lo) ? (log_hi - log_lo) : '0;
  assign num = (log_x > log_lo)  ? (log_x - log_lo)  : '0;

  ldbc_div #(
    .LW   (LW),
    .SB_W (SB_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (lg_ctl_q.vld),
    .num_i   (num),
    .den_i   (den),
    .side_i  ({lg_ctl_q.ok, lg_b_lo_q, lg_b_hi_q}),
    .vld_o   (dv_vld),
    .ratio_o (dv_ratio),
    .side_o  (dv_side)
  );

  assign dv_b_lo = dv_side[2*BrightW-1:BrightW];
  assign dv_b_hi = dv_side[BrightW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ml_ctl_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      ml_ctl_q.vld <= dv_vld;
      ml_ctl_q.ok  <= dv_side[SB_W-1];
      out_vld_q    <= ml_ctl_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    ml_b_lo_q <= dv_b_lo;
    ml_prod_q <= (RatioW+BrightW)'(dv_ratio) * (RatioW+BrightW)'(dv_b_hi - dv_b_lo);
    out_b_q   <= ml_b_lo_q + ml_prod_q[RatioW+BrightW-2:FracW];
    out_ok_q  <= ml_ctl_q.ok;
  end

  assign result_valid_o     = out_vld_q;
  assign brightness_level_o = out_b_q;
  assign curve_ok_o         = out_ok_q;

endmodule
`default_nettype wire

/* sv/ldbc_checker.sv */
// Port-level checks for the brightness curve block, bound to the top level.
`default_nettype none
module ldbc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        cfg_ready_o,
  input wire logic        result_valid_o,
  input wire logic [15:0] brightness_level_o,
  input wire logic        curve_ok_o
);

  localparam int Latency = 9;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency result_valid_o)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##Latency !result_valid_o)
    else $error("result without an accepted beat");

  a_bad_curve_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !curve_ok_o) |-> (brightness_level_o == 16'd0))
    else $error("invalid curve gave nonzero brightness");

  a_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_ready_o && !busy_o))
    else $error("block stalled a channel");

endmodule

bind log_domain_brightness_curve_top ldbc_checker u_ldbc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start_i),
  .busy_o             (busy_o),
  .cfg_ready_o        (cfg_ready_o),
  .result_valid_o     (result_valid_o),
  .brightness_level_o (brightness_level_o),
  .curve_ok_o         (curve_ok_o)
);
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the log-domain brightness curve block.
`timescale 1ns / 100ps
module tb_top;
  import ldbc_pkg::*;

  localparam int MaxPts = 7;
  localparam int LuxW = 17;
  localparam int Latency = 9;
  localparam logic [CfgIdxW-1:0] CfgPointBase = 3'd1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [LuxW-1:0] lux_reading_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [RegW-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [BrightW-1:0] brightness_level_o;
  logic curve_ok_o;

  typedef struct packed {
    logic [BrightW-1:0] level;
    logic ok;
  } bright_t;

  logic [LuxW-1:0] lux_backlog[$];
  bright_t level_due[$];
  int errors = 0;
  logic took = 1'b0;
  int gap_left = 0;

  // curve state mirrored by the checker
  logic [2:0] num_pts = '0;
  logic [RegW-1:0] pts[MaxPts];

  localparam logic [16:0] FracLog[17] = '{
    17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
    17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
    17'd56229, 17'd59434, 17'd62534, 17'd65536};

  log_domain_brightness_curve_top dut (.*);

  initial forever #4 clk_i = ~clk_i;

  function automatic logic [LuxW-1:0] pt_lux(int i);
    return pts[i][32:16];
  endfunction

  function automatic logic [15:0] pt_bri(int i);
    return pts[i][15:0];
  endfunction

  // log2(1+x) in Q5.16
  function automatic longint log2_fix(logic [LuxW-1:0] x);
    longint v, rest, f, k, r, lo, hi;
    int e;
    v = longint'(x) + 1;
    e = 0;
    while ((v >> (e + 1)) != 0) e++;
    rest = v - (longint'(1) << e);
    f = (e <= 16) ? (rest << (16 - e)) : (rest >> (e - 16));
    f = f & 16'hFFFF;
    k = f >> 12;
    r = f & 12'hFFF;
    lo = FracLog[k];
    hi = FracLog[k + 1];
    return (longint'(e) << 16) + lo + (((hi - lo) * r) >> 12);
  endfunction

  function automatic bright_t map_lux(logic [LuxW-1:0] lux);
    bright_t res;
    int last, seg;
    longint llo, lhi, lx, num, den, ratio;
    res = '0;
    if (num_pts < 2 || num_pts > MaxPts) return res;
    for (int i = 1; i < num_pts; i++) begin
      if (pt_lux(i) <= pt_lux(i - 1) || pt_bri(i) < pt_bri(i - 1)) return res;
    end
    res.ok = 1'b1;
    last = num_pts - 1;
    if (lux <= pt_lux(0)) begin
      res.level = pt_bri(0);
    end else if (lux >= pt_lux(last)) begin
      res.level = pt_bri(last);
    end else begin
      seg = 1;
      while (seg < last && lux >= pt_lux(seg)) seg++;
      llo = log2_fix(pt_lux(seg - 1));
      lhi = log2_fix(pt_lux(seg));
      lx = log2_fix(lux);
      den = (lhi > llo) ? lhi - llo : 0;
      num = (lx > llo) ? lx - llo : 0;
      if (den == 0) ratio = 0;
      else begin
        ratio = (num << 16) / den;
        if (ratio > 65536) ratio = 65536;
      end
      res.level = 16'(longint'(pt_bri(seg - 1)) +
                      ((ratio * (longint'(pt_bri(seg)) - pt_bri(seg - 1))) >> 16));
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: advance to the next reading once the current beat was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (lux_backlog.size() > 0) begin
        start_i <= 1'b1;
        lux_reading_i <= lux_backlog.pop_front();
        gap_left = pick_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: predict on each accepted reading, check each result beat
  always @(posedge clk_i) begin
    bright_t want;
    took <= start_i && !busy_o && rst_ni;
    if (rst_ni && start_i && !busy_o) level_due.push_back(map_lux(lux_reading_i));
    if (rst_ni && result_valid_o) begin
      if (level_due.size() == 0) begin
        $error("unexpected result beat: level %0d ok %0d", brightness_level_o, curve_ok_o);
        errors++;
      end else begin
        want = level_due.pop_front();
        if (brightness_level_o !== want.level) begin
          $error("brightness_level: expected %0d, got %0d", want.level, brightness_level_o);
          errors++;
        end
        if (curve_ok_o !== want.ok) begin
          $error("curve_ok: expected %0d, got %0d", want.ok, curve_ok_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_POINT_COUNT) num_pts = data[2:0];
    else pts[idx - CfgPointBase] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_curve(int cnt, logic [RegW-1:0] p[MaxPts]);
    write_reg(CFG_POINT_COUNT, RegW'(cnt));
    for (int i = 0; i < MaxPts; i++) write_reg(CfgPointBase + CfgIdxW'(i), p[i]);
  endtask

  task automatic drain();
    while (lux_backlog.size() > 0 || level_due.size() > 0 || start_i) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [LuxW-1:0] rand_lux();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 5) return LuxW'($urandom_range(0, 2000));
    return LuxW'($urandom);
  endfunction

  // random curve: mostly well-formed, sometimes broken or short
  task automatic rand_curve(output int cnt, output logic [RegW-1:0] p[MaxPts]);
    int roll;
    logic [LuxW-1:0] lx;
    logic [15:0] bv;
    roll = $urandom_range(0, 99);
    cnt = (roll < 8) ? $urandom_range(0, 1) : $urandom_range(2, MaxPts);
    lx = (roll % 3 == 0) ? '0 : LuxW'($urandom_range(0, 3000));
    bv = 16'($urandom_range(0, 20000));
    for (int i = 0; i < MaxPts; i++) begin
      p[i] = {lx, bv};
      lx = (lx > 17'd131071 - 17'd30000) ? 17'd131071 : lx + LuxW'($urandom_range(1, 30000));
      if (i == cnt - 2 && roll % 5 == 0) lx = '1;
      bv = (bv > 16'd55000) ? 16'hFFFF : bv + 16'($urandom_range(0, 10000));
    end
    if (roll >= 8 && roll < 16) p[$urandom_range(0, MaxPts - 1)] = RegW'({$urandom, $urandom});
  endtask

  initial begin
    logic [RegW-1:0] c[MaxPts];
    int cnt;
    foreach (pts[i]) pts[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset curve is invalid
    lux_backlog.push_back(17'd100);
    drain();

    // full range, two points
    foreach (c[i]) c[i] = '0;
    c[0] = {17'd0, 16'd0};
    c[1] = {17'd131071, 16'hFFFF};
    set_curve(2, c);
    foreach (lux_backlog[i]) ;
    lux_backlog = '{17'd0, 17'd1, 17'd2, 17'd65535, 17'd65536, 17'd131070, 17'd131071};
    drain();

    // seven points, nearly equal logs, flat segment
    c = '{{17'd10, 16'd100}, {17'd1000, 16'd5000}, {17'd1001, 16'd5000},
          {17'd126975, 16'd40000}, {17'd126976, 16'd60000},
          {17'd130000, 16'd65535}, {17'd131071, 16'hFFFF}};
    set_curve(7, c);
    lux_backlog = '{17'd0, 17'd10, 17'd500, 17'd1000, 17'd1001, 17'd126975,
                    17'd126976, 17'd129000, 17'd131071};
    drain();

    // lux not rising, then brightness falling, then too few points
    c[2] = {17'd1000, 16'd6000};
    set_curve(4, c);
    lux_backlog = '{17'd1000, 17'd50000};
    drain();
    c[2] = {17'd2000, 16'd4000};
    set_curve(4, c);
    lux_backlog = '{17'd1500};
    drain();
    set_curve(1, c);
    lux_backlog = '{17'd5};
    drain();

    for (int ph = 0; ph < 35; ph++) begin
      rand_curve(cnt, c);
      set_curve(cnt, c);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 2) == 0 && cnt > 0)
          lux_backlog.push_back(c[$urandom_range(0, cnt - 1)][32:16] +
                                LuxW'($urandom_range(0, 2)) - 17'd1);
        else lux_backlog.push_back(rand_lux());
      end
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
